>>> rtl/core/assert_macros.svh
// assertion macros shared by the console core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
// constants and types of the text console core
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int COPY_N  = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_READ    = 6'b000100,
    ST_SCROLL  = 6'b001000,
    ST_SDRAIN  = 6'b010000,
    ST_DELIVER = 6'b100000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  // first output field in the lowest bits
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/text_console_writer_core.sv
// Text console core: an 80x25 screen of 16-bit cells (character low byte, attribute high
// byte) held in one synchronous memory, plus a cursor. After reset the core clears every
// cell of the screen to blanks and takes no beat meanwhile. A character write or a newline
// that does not scroll is done in ST_IDLE; a cell read waits in ST_READ for the registered
// memory read data. A write that moves past the last row scrolls the screen: every cell
// goes through the single memory write port, through ST_SCROLL and ST_SDRAIN. One item is
// in work at a time; a result that waits on out_tready holds the core in ST_DELIVER, and no
// new beat is accepted until it is loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // color_attribute

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,      // char_code, read_row, read_col, zero pad
  input  wire logic [0:0]  in_tuser,      // kind

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata      // cell_char, cell_attr, cursor_col, cursor_row, pad
);

`include "assert_macros.svh"

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [CHAR_W-1:0] color_r;
  logic              rd_ok_r, rd_ok_nxt;
  logic              pipe_v_r, pipe_v_nxt;
  logic [ADDR_W-1:0] pipe_addr_r, pipe_addr_nxt;
  logic              pipe_fill_r, pipe_fill_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  mem_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rd_data;

  logic              in_accept;
  logic              in_kind;
  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic              slot_free;
  logic              fin;
  res_t              fin_res;
  logic              out_load;
  logic              wrap;

  assign in_kind = in_tuser[0];
  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign in_range = ({1'b0, in_row} < (ROW_W + 1)'(ROWS)) &&
                    ({1'b0, in_col} < (COL_W + 1)'(COLUMNS));
  assign rd_addr  = ADDR_W'(32'(in_row) * 32'(COLUMNS) + 32'(in_col));
  assign cur_addr = ADDR_W'(32'(cur_row_r) * 32'(COLUMNS) + 32'(cur_col_r));

  tcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    rd_ok_nxt     = rd_ok_r;
    pipe_v_nxt    = 1'b0;
    pipe_addr_nxt = cnt_r;
    pipe_fill_nxt = 1'b0;
    res_nxt       = res_r;
    raddr         = cnt_r;
    fin           = 1'b0;
    fin_res       = '0;
    out_load      = 1'b0;
    out_nxt       = out_r;
    wrap          = 1'b0;
    wr            = '0;

    if (pipe_v_r) begin
      wr.we   = 1'b1;
      wr.addr = pipe_addr_r;
      wr.data = pipe_fill_r ? {color_r, BLANK_CHAR} : rd_data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = cnt_r;
        wr.data = {RESET_ATTR, BLANK_CHAR};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == KIND_READ) begin
            raddr     = rd_addr;
            rd_ok_nxt = in_range;
            state_nxt = ST_READ;
          end else begin
            if (in_char == NEWLINE_CHAR) begin
              wrap = 1'b1;
            end else begin
              wr.we   = 1'b1;
              wr.addr = cur_addr;
              wr.data = {color_r, in_char};
              if (cur_col_r == COL_W'(COLUMNS - 1)) begin
                wrap = 1'b1;
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            if (wrap) begin
              cur_col_nxt = '0;
              if (cur_row_r == ROW_W'(ROWS - 1)) begin
                cnt_nxt   = '0;
                state_nxt = ST_SCROLL;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end
            if (state_nxt == ST_IDLE) begin
              fin                = 1'b1;
              fin_res.cursor_col = cur_col_nxt;
              fin_res.cursor_row = cur_row_nxt;
            end
          end
        end
      end
      ST_READ: begin
        fin                = 1'b1;
        fin_res.cell_char  = rd_ok_r ? rd_data[CHAR_W-1:0] : '0;
        fin_res.cell_attr  = rd_ok_r ? rd_data[CELL_W-1:CHAR_W] : '0;
        fin_res.cursor_col = cur_col_r;
        fin_res.cursor_row = cur_row_r;
      end
      ST_SCROLL: begin
        if (cnt_r < ADDR_W'(COPY_N)) begin
          raddr = cnt_r + ADDR_W'(COLUMNS);
        end
        pipe_v_nxt    = 1'b1;
        pipe_addr_nxt = cnt_r;
        pipe_fill_nxt = (cnt_r >= ADDR_W'(COPY_N));
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        fin                = 1'b1;
        fin_res.cursor_col = cur_col_r;
        fin_res.cursor_row = cur_row_r;
      end
      ST_DELIVER: begin
        if (slot_free) begin
          out_load  = 1'b1;
          out_nxt   = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (slot_free) begin
        out_load  = 1'b1;
        out_nxt   = fin_res;
        state_nxt = ST_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = ST_DELIVER;
      end
    end

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      color_r     <= RESET_ATTR;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    pipe_fill_r <= pipe_fill_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

  `TCW_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "result beat valid after reset")
  `TCW_ASSERT(a_cursor_range, (cur_row_r < ROW_W'(ROWS)) && (cur_col_r < COL_W'(COLUMNS)), "cursor off screen")
  `TCW_ASSERT(a_no_wr_clash, pipe_v_r |-> !in_accept, "input beat taken while scroll writes")
  `TCW_ASSERT(a_scroll_cursor, (state_r == ST_SDRAIN) |-> (cur_row_r == ROW_W'(ROWS - 1)) && (cur_col_r == '0), "cursor not at bottom row start after scroll")
  `TCW_ASSERT(a_clear_no_accept, (state_r == ST_CLEAR) |-> !in_tready, "ready during screen clear")

endmodule

`default_nettype wire

>>> rtl/core/tcw_screen_ram.sv
// screen cell memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
